// ===== hw/rtl/bet_pkg.sv =====
// Shared constants, types and character codes for the blank expander.
package bet_pkg;

  localparam int TAB_WIDTH       = 8;
  localparam int BLANK_COUNT_MAX = 127;
  localparam int MAX_RESULTS     = 64;
  localparam int QDEPTH          = 2;

  localparam int CH_W  = 7;
  localparam int BLK_W = 7;
  localparam int REP_W = 5;
  localparam int COL_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int QP_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W  = $clog2(QDEPTH + 1);

  localparam logic [CH_W-1:0] CH_TAB = 7'o011;
  localparam logic [CH_W-1:0] CH_NL  = 7'o012;
  localparam logic [CH_W-1:0] CH_FF  = 7'o014;
  localparam logic [CH_W-1:0] CH_ESC = 7'o033;
  localparam logic [CH_W-1:0] CH_SP  = 7'o040;

  localparam logic [CH_W-1:0] ESC_BLANK_BIT  = 7'o100;
  localparam logic [CH_W-1:0] ESC_REPEAT_BIT = 7'o040;
  localparam logic [CH_W-1:0] BLANK_MASK     = 7'o077;
  localparam logic [CH_W-1:0] REPEAT_MASK    = 7'o037;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESC    = 3'b010,
    MODE_REPEAT = 3'b100
  } mode_t;

  typedef struct packed {
    logic             is_eol;
    logic [BLK_W-1:0] blanks;
    logic [CH_W-1:0]  ch;
    logic [REP_W-1:0] reps;
  } cmd_t;

endpackage

// ===== hw/rtl/bet_front.sv =====
// Front end: decodes received characters into emission commands.
module bet_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char_in,
  input  logic          q_full,
  output logic          q_push,
  output bet_pkg::cmd_t q_cmd
);
  import bet_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [BLK_W-1:0] pend_r, pend_nxt;
  logic [REP_W-1:0] rep_r, rep_nxt;
  logic [CH_W-1:0]  c;
  logic [BLK_W-1:0] add_k;
  logic             do_add;
  logic [BLK_W:0]   sum;
  logic             acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign c        = in_char_in[CH_W-1:0];
  assign sum      = {1'b0, pend_r} + {1'b0, add_k};

  always_comb begin
    mode_nxt     = MODE_NORMAL;
    rep_nxt      = rep_r;
    pend_nxt     = pend_r;
    add_k        = '0;
    do_add       = 1'b0;
    q_push       = 1'b0;
    q_cmd.is_eol = 1'b0;
    q_cmd.blanks = pend_r;
    q_cmd.ch     = c;
    q_cmd.reps   = REP_W'(1);
    if (mode_r == MODE_ESC) begin
      if ((c & ESC_BLANK_BIT) != '0) begin
        add_k  = c & BLANK_MASK;
        do_add = 1'b1;
      end else if ((c & ESC_REPEAT_BIT) != '0 && (c & REPEAT_MASK) != '0) begin
        rep_nxt  = REP_W'(c & REPEAT_MASK);
        mode_nxt = MODE_REPEAT;
      end
    end else if (mode_r == MODE_REPEAT && c >= CH_SP) begin
      if (c > CH_SP) begin
        q_push     = 1'b1;
        q_cmd.reps = rep_r;
        pend_nxt   = '0;
      end else begin
        add_k  = BLK_W'(rep_r);
        do_add = 1'b1;
      end
    end else begin
      if (c > CH_SP) begin
        q_push   = 1'b1;
        pend_nxt = '0;
      end else if (c == CH_SP) begin
        add_k  = BLK_W'(1);
        do_add = 1'b1;
      end else if (c == CH_NL || c == CH_FF) begin
        q_push       = 1'b1;
        q_cmd.is_eol = 1'b1;
        q_cmd.blanks = '0;
        pend_nxt     = '0;
      end else if (c == CH_ESC) begin
        mode_nxt = MODE_ESC;
      end
    end
    if (do_add) begin
      pend_nxt = (sum > (BLK_W+1)'(BLANK_COUNT_MAX)) ? BLK_W'(BLANK_COUNT_MAX)
                                                      : sum[BLK_W-1:0];
    end
    if (!acc) begin
      q_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      pend_r <= '0;
      rep_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      rep_r  <= rep_nxt;
    end
  end

endmodule

// ===== hw/rtl/bet_queue.sv =====
// Short command queue between the decoder and the expander.
module bet_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bet_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output bet_pkg::cmd_t pop_cmd
);
  import bet_pkg::*;

  cmd_t            q_r [QDEPTH];
  logic [QP_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == QC_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_cmd  = q_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(QDEPTH - 1)) ? '0 : p + QP_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= ptr_inc(wp_r);
      end
      if (do_pop) begin
        rp_r <= ptr_inc(rp_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/bet_back.sv =====
// Back end: expands blanks into tabs and spaces and emits characters.
module bet_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_nonempty,
  input  bet_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [bet_pkg::CH_W-1:0] out_char_out,
  output logic                  out_last_of_run
);
  import bet_pkg::*;

  logic             busy_r;
  logic             eol_r;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [REP_W-1:0] rep_r, rep_nxt;
  logic [CH_W-1:0]  ch_r, emit_ch;
  logic [COL_W-1:0] col_r, col_nxt, col_inc;
  logic [CNT_W-1:0] cnt_r;
  logic [BLK_W-1:0] tab_gap;
  logic             ovalid_r, olast_r;
  logic [CH_W-1:0]  ochar_r;
  logic             step, fin, emit;

  assign out_valid       = ovalid_r;
  assign out_char_out    = ochar_r;
  assign out_last_of_run = olast_r;

  assign q_pop   = !busy_r && q_nonempty;
  assign step    = busy_r && (!ovalid_r || out_ready);
  assign col_inc = (col_r == COL_W'(TAB_WIDTH - 1)) ? '0 : col_r + COL_W'(1);
  assign tab_gap = BLK_W'(TAB_WIDTH) - BLK_W'(col_r);

  always_comb begin
    blk_nxt = blk_r;
    rep_nxt = rep_r;
    col_nxt = col_r;
    emit_ch = ch_r;
    if (blk_r != '0) begin
      if (blk_r >= tab_gap && tab_gap != BLK_W'(1)) begin
        emit_ch = CH_TAB;
        blk_nxt = blk_r - tab_gap;
        col_nxt = '0;
      end else begin
        emit_ch = CH_SP;
        blk_nxt = blk_r - BLK_W'(1);
        col_nxt = col_inc;
      end
    end else begin
      rep_nxt = rep_r - REP_W'(1);
      col_nxt = eol_r ? '0 : col_inc;
    end
  end

  assign fin  = (blk_nxt == '0) && (rep_nxt == '0);
  assign emit = (cnt_r < CNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      eol_r <= q_cmd.is_eol;
      ch_r  <= q_cmd.ch;
    end
    if (step && emit) begin
      ochar_r <= emit_ch;
      olast_r <= fin || (cnt_r == CNT_W'(MAX_RESULTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      blk_r    <= '0;
      rep_r    <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (step && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        blk_r  <= q_cmd.blanks;
        rep_r  <= q_cmd.reps;
        cnt_r  <= '0;
      end else if (step) begin
        blk_r <= blk_nxt;
        rep_r <= rep_nxt;
        col_r <= col_nxt;
        if (emit) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (fin) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/blank_expand_tab_compress.sv =====
// Top level of the blank-compression decoder with tab insertion.
// Takes one received character per input transaction and rebuilds print lines:
// blanks and ESC codes are decoded into commands by the front end, queued in a
// two-entry command queue, and expanded by the back end into tabs at 8-column
// stops, spaces and repeated characters. An input transaction is accepted
// whenever the queue has room. Each command is first loaded into the back end,
// which then emits its tabs, spaces and characters one character per cycle
// while the output is not stalled, and loads the next command only once it has
// finished the current one; the back end's emitter sets the sustained rate.
module blank_expand_tab_compress (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_char_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bet_pkg::CH_W-1:0] out_char_out,
  output logic                     out_last_of_run
);
  import bet_pkg::*;

  logic push, full, pop, nonempty;
  cmd_t push_cmd, pop_cmd;

  bet_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .q_full     (full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  bet_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .pop_cmd  (pop_cmd)
  );

  bet_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (nonempty),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== sim/blank_expand_tab_compress_test.sv =====
// Self-checking testbench for the blank-compression decoder with tab insertion.
module blank_expand_tab_compress_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bet_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TIME  = 50;
  localparam int RANDOM_ITEMS = 170;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } line_char_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_char_in;
  logic            out_valid;
  logic            out_ready;
  logic [CH_W-1:0] out_char_out;
  logic            out_last_of_run;

  line_char_t line_q[$];
  mode_t      decode_mode;
  int         blank_cnt;
  int         col_pos;
  int         repeat_cnt;
  int         step_chars;
  int         sent_cnt;
  int         random_cnt;
  int         checked_cnt;
  int         error_cnt;
  int         stall_cnt;
  bit         steady;

  blank_expand_tab_compress uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void emit_char(input logic [CH_W-1:0] c);
    line_char_t e;
    if (step_chars < MAX_RESULTS) begin
      e.ch   = c;
      e.last = 1'b0;
      line_q.push_back(e);
    end
    step_chars++;
  endfunction

  function automatic void add_blanks(input int k);
    blank_cnt = (blank_cnt + k > BLANK_COUNT_MAX) ? BLANK_COUNT_MAX : blank_cnt + k;
  endfunction

  function automatic void advance_col();
    col_pos = (col_pos + 1) % TAB_WIDTH;
  endfunction

  function automatic void flush_blanks();
    int d;
    while (blank_cnt != 0) begin
      d = TAB_WIDTH - col_pos;
      if (blank_cnt < d || d == 1) begin
        emit_char(CH_SP);
        blank_cnt--;
        advance_col();
      end else begin
        emit_char(CH_TAB);
        blank_cnt -= d;
        col_pos = 0;
      end
    end
  endfunction

  function automatic void plain_char(input logic [CH_W-1:0] c);
    if (c > CH_SP) begin
      flush_blanks();
      emit_char(c);
      advance_col();
    end else if (c == CH_SP) begin
      add_blanks(1);
    end else if (c == CH_NL || c == CH_FF) begin
      emit_char(c);
      blank_cnt = 0;
      col_pos   = 0;
    end else if (c == CH_ESC) begin
      decode_mode = MODE_ESC;
    end
  endfunction

  function automatic void expand_char(input logic [7:0] b);
    logic [CH_W-1:0] c;
    int              base;
    c          = b[CH_W-1:0];
    base       = line_q.size();
    step_chars = 0;
    case (decode_mode)
      MODE_ESC: begin
        decode_mode = MODE_NORMAL;
        if ((c & ESC_BLANK_BIT) != 0) begin
          add_blanks(int'(c & BLANK_MASK));
        end else if ((c & ESC_REPEAT_BIT) != 0 && (c & REPEAT_MASK) != 0) begin
          repeat_cnt  = int'(c & REPEAT_MASK);
          decode_mode = MODE_REPEAT;
        end
      end
      MODE_REPEAT: begin
        decode_mode = MODE_NORMAL;
        if (c > CH_SP) begin
          flush_blanks();
          repeat (repeat_cnt) begin
            emit_char(c);
            advance_col();
          end
        end else if (c == CH_SP) begin
          add_blanks(repeat_cnt);
        end else begin
          plain_char(c);
        end
      end
      default: begin
        decode_mode = MODE_NORMAL;
        plain_char(c);
      end
    endcase
    if (line_q.size() > base)
      line_q[line_q.size()-1].last = 1'b1;
  endfunction

  always @(negedge clk) begin
    out_ready <= rst_n && (steady || $urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    line_char_t e;
    if (rst_n && out_valid && out_ready) begin
      checked_cnt++;
      if (line_q.size() == 0) begin
        $display("%0t: unexpected output char %0h last %0b", $time, out_char_out,
                 out_last_of_run);
        error_cnt++;
      end else begin
        e = line_q.pop_front();
        if (out_char_out !== e.ch) begin
          $display("%0t: char_out expected %0h actual %0h", $time, e.ch, out_char_out);
          error_cnt++;
        end
        if (out_last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last,
                   out_last_of_run);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_char(input logic [7:0] b);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 8) ? 1 : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= b;
    do @(posedge clk); while (!in_ready);
    expand_char(b);
    sent_cnt++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_top(input logic [CH_W-1:0] c);
    return {$urandom_range(0, 1) == 1, c};
  endfunction

  task automatic test_printables();
    send_char(8'h21);
    send_char(8'h7F);
    send_char(8'hFE);
  endtask

  task automatic test_controls();
    send_char(8'h80);
    send_char({1'b0, CH_TAB});
    send_char({1'b1, CH_FF});
    send_char({1'b0, CH_SP});
    send_char({1'b0, CH_NL});
  endtask

  task automatic test_blank_runs();
    send_char(8'h41);
    send_char({1'b0, CH_SP});
    send_char({1'b1, CH_SP});
    send_char({1'b0, CH_ESC});
    send_char({1'b0, ESC_BLANK_BIT | BLANK_MASK});
    send_char({1'b1, CH_ESC});
    send_char({1'b1, ESC_BLANK_BIT | BLANK_MASK});
    send_char(8'h42);
  endtask

  task automatic test_escape_codes();
    send_char({1'b0, CH_ESC});
    send_char({1'b0, ESC_REPEAT_BIT});
    send_char({1'b0, CH_ESC});
    send_char(8'h10);
  endtask

  task automatic test_repeats();
    send_char({1'b0, CH_ESC});
    send_char({1'b1, ESC_REPEAT_BIT | REPEAT_MASK});
    send_char(8'h78);
    send_char({1'b0, CH_ESC});
    send_char(8'h25);
    send_char({1'b0, CH_SP});
    send_char(8'h61);
    send_char({1'b0, CH_ESC});
    send_char(8'h22);
    send_char({1'b0, CH_ESC});
    send_char(8'h41);
    send_char(8'h7A);
  endtask

  task automatic test_random_lines();
    int start;
    int pick;
    int code;
    bit drained;
    start   = sent_cnt;
    drained = 1'b0;
    while (sent_cnt - start < RANDOM_ITEMS) begin
      steady = (sent_cnt - start >= 60 && sent_cnt - start < 120);
      if (!drained && sent_cnt - start >= 100) begin
        wait_drain();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_char(any_top(7'($urandom_range(8'h21, 8'h7F))));
      end else if (pick < 58) begin
        repeat ($urandom_range(1, 12)) send_char(any_top(CH_SP));
      end else if (pick < 70) begin
        send_char(any_top(CH_ESC));
        send_char(any_top(ESC_BLANK_BIT | 7'($urandom_range(0, 63))));
      end else if (pick < 84) begin
        send_char(any_top(CH_ESC));
        code = $urandom_range(0, 99);
        if (code < 70)
          send_char(any_top(ESC_REPEAT_BIT | 7'($urandom_range(0, 31))));
        else
          send_char(any_top(7'($urandom_range(0, 31))));
        code = $urandom_range(0, 9);
        if (code < 6)
          send_char(any_top(7'($urandom_range(8'h21, 8'h7F))));
        else if (code < 8)
          send_char(any_top(CH_SP));
        else
          send_char(any_top(7'($urandom_range(0, 31))));
      end else if (pick < 92) begin
        send_char(any_top(($urandom_range(0, 1) == 1) ? CH_NL : CH_FF));
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end
    steady     = 1'b0;
    random_cnt = sent_cnt - start;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_char_in  = 8'h00;
    out_ready   = 1'b0;
    steady      = 1'b0;
    stall_cnt   = 0;
    sent_cnt    = 0;
    random_cnt  = 0;
    checked_cnt = 0;
    error_cnt   = 0;
    decode_mode = MODE_NORMAL;
    blank_cnt   = 0;
    col_pos     = 0;
    repeat_cnt  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_printables();
    test_controls();
    test_blank_runs();
    test_escape_codes();
    test_repeats();
    test_random_lines();

    wait_drain();
    repeat (SETTLE_TIME) @(posedge clk);
    $display("Sent %0d characters (%0d random), checked %0d output characters,",
             sent_cnt, random_cnt, checked_cnt);
    $display("covering blank runs, saturation, ESC blank/repeat codes and controls.");
    if (error_cnt == 0 && line_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== blank_expand_tab_compress.f =====
hw/rtl/bet_pkg.sv
hw/rtl/bet_front.sv
hw/rtl/bet_queue.sv
hw/rtl/bet_back.sv
hw/rtl/blank_expand_tab_compress.sv
sim/blank_expand_tab_compress_test.sv
